// ===== sv/m5mf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m5mf_pkg - shared types and constants for the five-tap median filter
// Sample type, window sizes and counter widths used by the top level and
// the shared-comparator median unit.
// ----------------------------------------------------------------------------
package m5mf_pkg;

   localparam int SAMPLE_BITS = 24;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Five-tap median window, and the seven-entry work buffer that holds
   // the windows of up to three flushed outputs.
   localparam int WIN_TAPS = 5;
   localparam int BUF_TAPS = 7;
   localparam int HIST_TAPS = 4;

   // Results owed by one input beat: at most three.
   localparam int REM_BITS = 2;

   // Saturating count of samples seen in the current signal.
   typedef enum logic [1:0] {
      SEEN_NONE = 2'd0,
      SEEN_ONE  = 2'd1,
      SEEN_MANY = 2'd2
   } seen_type;

endpackage

// ===== sv/m5mf_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m5mf_median - median of five through one shared comparator
// Removes the smallest value twice and then takes the minimum of the last
// three: nine compares plus three line moves per median.
// ----------------------------------------------------------------------------
module m5mf_median (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  m5mf_pkg::sample_type window [m5mf_pkg::WIN_TAPS],
   output logic                 busy,
   output logic                 done,
   output m5mf_pkg::sample_type median
);
   import m5mf_pkg::*;

   // Step schedule: compares everywhere except the moves below.
   localparam int STEP_BITS  = 4;
   localparam logic [STEP_BITS-1:0] STEP_LOAD2 = 4'd4;   // start of pass two
   localparam logic [STEP_BITS-1:0] STEP_SKIP  = 4'd8;   // drop filler slot
   localparam logic [STEP_BITS-1:0] STEP_LOAD3 = 4'd9;   // start of pass three
   localparam logic [STEP_BITS-1:0] STEP_LAST  = 4'd11;

   localparam int LINE_TAPS = WIN_TAPS - 1;

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_BITS-1:0] step_ff;
   sample_type           cur_ff, cur_in;
   sample_type           line_ff [LINE_TAPS];
   sample_type           line_in [LINE_TAPS];
   sample_type           head;
   logic                 less;

   assign head = line_ff[0];
   assign less = head < cur_ff;

   always_comb begin
      for (int i = 0; i < LINE_TAPS - 1; i++) begin
         line_in[i] = line_ff[i+1];
      end
      case (step_ff)
         STEP_LOAD2, STEP_LOAD3: begin
            cur_in              = head;
            line_in[LINE_TAPS-1] = head;
         end
         STEP_SKIP: begin
            cur_in              = cur_ff;
            line_in[LINE_TAPS-1] = head;
         end
         default: begin
            // running minimum stays, the loser goes to the tail
            cur_in              = less ? head : cur_ff;
            line_in[LINE_TAPS-1] = less ? cur_ff : head;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         cur_ff <= cur_in;
         for (int i = 0; i < LINE_TAPS; i++) begin
            line_ff[i] <= line_in[i];
         end
      end else if (start) begin
         cur_ff <= window[0];
         for (int i = 0; i < LINE_TAPS; i++) begin
            line_ff[i] <= window[i+1];
         end
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign median = cur_ff;

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(step_ff) == STEP_LAST)
      else $error("median done without a finished sweep");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("median start while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("median done longer than one cycle");

endmodule

// ===== sv/median5_mirror_filter_unit.sv =====
`timescale 1ns / 1ps
// Flow: a beat that owes results goes to START (launch the median unit),
//   WAIT (comparator steps until done) and OUT (into the rsp_ register,
//   held while rsp_ is full). Each further flushed result repeats START,
//   WAIT and OUT; a final beat owes up to 3. Beats: a beat with no result
//   leaves req_ready high; else req_ready is low until its last result is out.
// Reset (synchronous, active high) clears history, count, sequencer, rsp_valid.
// ----------------------------------------------------------------------------
// median5_mirror_filter_unit - five-tap median filter with mirrored ends
// Streams a signal one sample per beat and returns one median per position,
// with the signal ends mirrored so the output is as long as the input.
// ----------------------------------------------------------------------------
module median5_mirror_filter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  m5mf_pkg::sample_type req_sample_in,
   input  logic                 req_is_final,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output m5mf_pkg::sample_type rsp_sample_out,
   output logic                 rsp_final_out
);
   import m5mf_pkg::*;

   // IDLE takes a beat; START launches the median unit on buf[0..4];
   // WAIT holds until it is done; OUT moves the result to the rsp_ register
   // and slides the work buffer by one for the next flushed position.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type            state_ff;
   seen_type             seen_ff, seen_in;
   sample_type           hist_ff [HIST_TAPS];   // [0] most recent position
   sample_type           hist_in [HIST_TAPS];
   sample_type           buf_ff  [BUF_TAPS];
   sample_type           load_buf [BUF_TAPS];
   logic [REM_BITS-1:0]  rem_ff, load_rem;
   logic                 load_go;
   logic                 fin_ff;
   logic                 rsp_valid_ff;
   sample_type           rsp_sample_ff;
   logic                 rsp_final_ff;

   logic                 accept;
   logic                 out_free;
   logic                 med_start;
   logic                 med_busy;
   logic                 med_done;
   sample_type           med_result;
   sample_type           med_window [WIN_TAPS];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign med_start = (state_ff == ST_START);

   always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
         med_window[i] = buf_ff[i];
      end
   end

   // What one accepted beat does to the history, and which windows it owes.
   always_comb begin
      sample_type x;
      sample_type s0;
      x        = req_sample_in;
      s0       = hist_ff[0];
      load_go  = 1'b1;
      load_rem = REM_BITS'(1);
      seen_in  = seen_ff;
      for (int i = 0; i < HIST_TAPS; i++) begin
         hist_in[i] = hist_ff[i];
      end
      for (int i = 0; i < BUF_TAPS; i++) begin
         load_buf[i] = x;
      end
      if (!req_is_final) begin
         case (seen_ff)
            SEEN_NONE: begin
               load_go    = 1'b0;
               hist_in[0] = x;
               seen_in    = SEEN_ONE;
            end
            SEEN_ONE: begin
               // positions -2..1 become s1, s0, s0, s1
               load_go    = 1'b0;
               hist_in[3] = x;
               hist_in[2] = s0;
               hist_in[1] = s0;
               hist_in[0] = x;
               seen_in    = SEEN_MANY;
            end
            default: begin
               load_buf[0] = hist_ff[3];
               load_buf[1] = hist_ff[2];
               load_buf[2] = hist_ff[1];
               load_buf[3] = hist_ff[0];
               hist_in[3]  = hist_ff[2];
               hist_in[2]  = hist_ff[1];
               hist_in[1]  = hist_ff[0];
               hist_in[0]  = x;
            end
         endcase
      end else begin
         // end of signal: flush and start over
         seen_in = SEEN_NONE;
         for (int i = 0; i < HIST_TAPS; i++) begin
            hist_in[i] = '0;
         end
         case (seen_ff)
            SEEN_NONE: begin
               // single-sample signal: window of five copies passes it through
               load_rem = REM_BITS'(1);
            end
            SEEN_ONE: begin
               load_rem    = REM_BITS'(2);
               load_buf[1] = s0;
               load_buf[2] = s0;
               load_buf[5] = s0;
            end
            default: begin
               load_rem    = REM_BITS'(3);
               load_buf[0] = hist_ff[3];
               load_buf[1] = hist_ff[2];
               load_buf[2] = hist_ff[1];
               load_buf[3] = hist_ff[0];
               load_buf[6] = hist_ff[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= SEEN_NONE;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HIST_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         // a new result beat may replace the one leaving in the same cycle
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  seen_ff <= seen_in;
                  for (int i = 0; i < HIST_TAPS; i++) begin
                     hist_ff[i] <= hist_in[i];
                  end
                  if (load_go) begin
                     rem_ff   <= load_rem;
                     state_ff <= ST_START;
                  end
               end
            end
            ST_START: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (med_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rem_ff       <= rem_ff - 1'b1;
                  state_ff     <= (rem_ff == REM_BITS'(1)) ? ST_IDLE : ST_START;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath registers: work buffer, final flag and result beat.
   always_ff @(posedge clock) begin
      if (accept && load_go) begin
         fin_ff <= req_is_final;
         for (int i = 0; i < BUF_TAPS; i++) begin
            buf_ff[i] <= load_buf[i];
         end
      end else if (state_ff == ST_OUT && out_free) begin
         for (int i = 0; i < BUF_TAPS - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
         buf_ff[BUF_TAPS-1] <= buf_ff[BUF_TAPS-1];
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_sample_ff <= med_result;
         rsp_final_ff  <= fin_ff && (rem_ff == REM_BITS'(1));
      end
   end

   m5mf_median u_median (
      .clock  (clock),
      .reset  (reset),
      .start  (med_start),
      .window (med_window),
      .busy   (med_busy),
      .done   (med_done),
      .median (med_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_final_out  = rsp_final_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      med_done |-> state_ff == ST_WAIT)
      else $error("median result arrived outside the wait state");

   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> rem_ff != '0)
      else $error("sequencer running with no result owed");

   a_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && !med_done |-> med_busy)
      else $error("waiting on an idle median unit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_sample_ff))
      else $error("pending result beat overwritten");

endmodule

// ===== tb/tb_median5_mirror_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median5_mirror_filter_unit - self-checking bench for the median filter
// Streams signals of random length and content through the filter under
// random idle and stall patterns. Predicts every median and end flag at each
// accepted request beat, and checks response beats against them in order.
// ----------------------------------------------------------------------------
module tb_median5_mirror_filter_unit;
   import m5mf_pkg::*;

   // One expected response beat: the window median and its end-of-signal flag.
   typedef struct packed {
      sample_type sample;
      logic       is_last;
   } median_beat_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int MAX_IDLE     = 18;
   localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 60;     // three flushed results plus margin
   localparam int RANDOM_BEATS = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_sample_in = '0;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   sample_type rsp_sample_out;
   logic       rsp_final_out;

   median5_mirror_filter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_is_final   (req_is_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_final_out  (rsp_final_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected medians, oldest first, and the predictor's copy of the window.
   median_beat_type pending_medians [$];
   sample_type   win_hist [HIST_TAPS];
   seen_type     win_seen = SEEN_NONE;

   int error_count = 0;
   int beats_sent  = 0;

   // Idle knobs: upper bound of the per-beat gap on each side. Zero gives a
   // stretch with no idling at all.
   int req_max_gap   = MAX_IDLE;
   int rsp_max_stall = MAX_IDLE;

   // Bumped by a test to start one long hold-off; the receiver counts it.
   int hold_gen = 0;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Median by rank: the value with at most two below it and at least three
   // at or below it. Ties resolve to an equal value either way.
   function automatic sample_type median_of_five(input sample_type a, input sample_type b,
                                                 input sample_type c, input sample_type d,
                                                 input sample_type e);
      sample_type v [WIN_TAPS];
      int below;
      int not_above;
      v = '{a, b, c, d, e};
      for (int i = 0; i < WIN_TAPS; i++) begin
         below = 0;
         not_above = 0;
         for (int j = 0; j < WIN_TAPS; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 2 && not_above >= 3) return v[i];
      end
      return v[0];
   endfunction

   task automatic push_median(input sample_type s, input logic is_last);
      median_beat_type m;
      m.sample = s;
      m.is_last = is_last;
      pending_medians = {pending_medians, m};
   endtask

   // Advance the predicted window by one accepted sample and queue the
   // medians it releases.
   task automatic predict_medians(input sample_type x, input logic is_last);
      sample_type s0;
      s0 = win_hist[0];
      if (!is_last) begin
         case (win_seen)
            SEEN_NONE: begin
               win_hist[0] = x;
               win_seen = SEEN_ONE;
            end
            SEEN_ONE: begin
               // window before position 0 is mirrored: s1, s0, s0, s1
               win_hist[3] = x;
               win_hist[2] = s0;
               win_hist[1] = s0;
               win_hist[0] = x;
               win_seen = SEEN_MANY;
            end
            default: begin
               push_median(median_of_five(win_hist[3], win_hist[2], win_hist[1],
                                          win_hist[0], x), 1'b0);
               win_hist[3] = win_hist[2];
               win_hist[2] = win_hist[1];
               win_hist[1] = win_hist[0];
               win_hist[0] = x;
            end
         endcase
      end else begin
         case (win_seen)
            SEEN_NONE: push_median(x, 1'b1);
            SEEN_ONE: begin
               push_median(median_of_five(x, s0, s0, x, x), 1'b0);
               push_median(median_of_five(s0, s0, x, x, s0), 1'b1);
            end
            default: begin
               // tail mirrored as s[N-1], s[N-2]
               push_median(median_of_five(win_hist[3], win_hist[2], win_hist[1],
                                          win_hist[0], x), 1'b0);
               push_median(median_of_five(win_hist[2], win_hist[1], win_hist[0],
                                          x, x), 1'b0);
               push_median(median_of_five(win_hist[1], win_hist[0], x, x,
                                          win_hist[0]), 1'b1);
            end
         endcase
         for (int i = 0; i < HIST_TAPS; i++) win_hist[i] = '0;
         win_seen = SEEN_NONE;
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: checks each accepted beat and owns rsp_ready.
   // -------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;
   int hold_seen  = 0;

   always @(posedge clock) begin
      median_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected response beat: expected none, actual %0d/%0b",
                     $time, rsp_sample_out, rsp_final_out);
            error_count++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_sample_out !== want.sample) begin
               $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                        $time, want.sample, rsp_sample_out);
               error_count++;
            end
            if (rsp_final_out !== want.is_last) begin
               $display("%0t: final_out mismatch: expected %0b, actual %0b",
                        $time, want.is_last, rsp_final_out);
               error_count++;
            end
         end
         stall_left = $urandom_range(0, rsp_max_stall);
      end
      if (hold_gen != hold_seen) begin
         hold_seen = hold_gen;
         hold_left = HOLD_CYCLES;
      end
      // one NBA per edge: the hold-off wins, then the per-beat stall
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Called at a rising edge. req_valid is left high after the beat is taken,
   // so back-to-back beats never lower and raise it in the same step.
   task automatic send_beat(input sample_type s, input logic is_last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      req_is_final  <= is_last;
      do @(posedge clock); while (!req_ready);
      predict_medians(s, is_last);
      beats_sent++;
   endtask

   // Sender goes quiet until every owed median is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_medians.size() != 0);
   endtask

   // Sample styles: 0 full range, 1 a few small values (lots of ties),
   // 2 range extremes, zero and minus one, 3 any of these per sample.
   function automatic sample_type draw_sample(input int style);
      int pick;
      pick = (style == 3) ? $urandom_range(0, 2) : style;
      case (pick)
         0: return sample_type'($urandom);
         1: return sample_type'(int'($urandom_range(0, 6)) - 3);
         default: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return sample_type'(0);
               default: return sample_type'(-1);
            endcase
         end
      endcase
   endfunction

   task automatic send_signal(input int len, input int style);
      for (int i = 0; i < len; i++) send_beat(draw_sample(style), i == len - 1);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Signals of length one and two, the first long-signal ending, range
   // extremes, ties, and alternating extremes.
   task automatic test_directed_edges();
      send_beat(SAMPLE_MAX, 1'b1);
      send_beat(SAMPLE_MIN, 1'b1);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(SAMPLE_MAX, 1'b1);
      send_beat(sample_type'(0), 1'b0);
      send_beat(sample_type'(-1), 1'b0);
      send_beat(sample_type'(1), 1'b1);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(sample_type'(0), 1'b0);
      send_beat(sample_type'(-1), 1'b0);
      send_beat(SAMPLE_MIN, 1'b1);
      for (int i = 0; i < 4; i++) send_beat(sample_type'(17), i == 3);
      for (int i = 0; i < 6; i++) send_beat(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i == 5);
   endtask

   // Random signals, mostly short, a few long; idle profile per signal.
   task automatic test_random_signals();
      int len;
      int start;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         case ($urandom_range(0, 19))
            0: len = $urandom_range(25, 60);
            1, 2, 3, 4, 5: len = $urandom_range(9, 24);
            default: len = $urandom_range(1, 8);
         endcase
         req_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
         rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
         send_signal(len, $urandom_range(0, 3));
      end
      req_max_gap   = MAX_IDLE;
      rsp_max_stall = MAX_IDLE;
   endtask

   // Receiver holds off while the sender streams with no gaps, so the
   // filter fills and pushes back on req_ready.
   task automatic test_output_backpressure();
      req_max_gap = 0;
      hold_gen++;
      send_signal(20, 0);
      send_signal(12, 3);
      req_max_gap = MAX_IDLE;
      wait_drained();
   endtask

   // Sender pauses mid-signal until all owed medians are back; the window
   // must survive the idle time.
   task automatic test_pause_mid_signal();
      for (int i = 0; i < 5; i++) send_beat(draw_sample(0), 1'b0);
      wait_drained();
      for (int i = 0; i < 3; i++) send_beat(draw_sample(3), 1'b0);
      wait_drained();
      send_beat(draw_sample(0), 1'b1);
      send_beat(draw_sample(0), 1'b0);
      wait_drained();
      send_beat(draw_sample(0), 1'b1);
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < HIST_TAPS; i++) win_hist[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_pause_mid_signal();
      test_random_signals();
      test_output_backpressure();

      wait_drained();
      // watch for stray beats after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_medians.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Worst case for ~500 beats is far below this.
   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d medians outstanding", $time, pending_medians.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
